/* rtl/oldq_pkg.sv */
// Package for the ordered list deque engine: sizes, operation and status codes,
// and the command struct between the controller and the datapath.
// Depends on nothing; every other file of the block uses it.
package oldq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic signed [DATA_W-1:0]  data_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_SEARCH     = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic apply;
  } cmd_t;

endpackage

/* rtl/oldq_dp.sv */
// Datapath of the ordered list deque engine: the row of entry cells, the
// parallel compare stage, the fill count and the result registers.
// Depends on oldq_pkg; driven by commands from oldq_ctrl.
module oldq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oldq_pkg::cmd_t                    cmd,
  input  logic [oldq_pkg::OP_W-1:0]         in_op,
  input  logic signed [oldq_pkg::DATA_W-1:0] in_value,
  output logic [oldq_pkg::STAT_W-1:0]       out_status,
  output logic                              out_hit,
  output logic [oldq_pkg::COUNT_W-1:0]      out_count
);

  oldq_pkg::data_t                entries_r [oldq_pkg::DEPTH];
  oldq_pkg::data_t                entries_nxt [oldq_pkg::DEPTH];
  oldq_pkg::cnt_t                 count_r;
  oldq_pkg::cnt_t                 count_nxt;
  logic [oldq_pkg::OP_W-1:0]      op_r;
  oldq_pkg::data_t                value_r;
  logic [oldq_pkg::DEPTH-1:0]     match_r;
  logic [oldq_pkg::DEPTH-1:0]     match_nxt;
  logic [oldq_pkg::DEPTH-1:0]     first_hit;
  logic [oldq_pkg::DEPTH-1:0]     shift_mask;
  logic                           any_hit;
  logic                           full;
  logic                           empty;
  oldq_pkg::status_t              status_nxt;
  logic                           hit_nxt;
  logic [oldq_pkg::STAT_W-1:0]    status_r;
  logic                           hit_r;
  oldq_pkg::count_t               out_count_r;

  always_comb begin
    for (int i = 0; i < oldq_pkg::DEPTH; i++) begin
      match_nxt[i] = (entries_r[i] == value_r) && (oldq_pkg::cnt_t'(i) < count_r);
    end
  end

  // Lowest set match bit is the entry nearest the front; it and all cells
  // behind it take their neighbor's value when that entry is removed.
  assign first_hit  = match_r & (~match_r + 1'b1);
  assign shift_mask = ~(first_hit - 1'b1);
  assign any_hit    = |match_r;
  assign full       = (count_r == oldq_pkg::cnt_t'(oldq_pkg::DEPTH));
  assign empty      = (count_r == '0);

  always_comb begin
    for (int i = 0; i < oldq_pkg::DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    count_nxt  = count_r;
    status_nxt = oldq_pkg::ST_DONE;
    hit_nxt    = 1'b0;
    case (op_r)
      oldq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = oldq_pkg::ST_FULL;
        end else begin
          entries_nxt[0] = value_r;
          for (int i = 1; i < oldq_pkg::DEPTH; i++) begin
            entries_nxt[i] = entries_r[i-1];
          end
          count_nxt = count_r + 1'b1;
        end
      end
      oldq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = oldq_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < oldq_pkg::DEPTH; i++) begin
            if (oldq_pkg::cnt_t'(i) == count_r) begin
              entries_nxt[i] = value_r;
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      oldq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = oldq_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < oldq_pkg::DEPTH - 1; i++) begin
            entries_nxt[i] = entries_r[i+1];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      oldq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_nxt = oldq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      oldq_pkg::OP_REMOVE: begin
        if (empty) begin
          status_nxt = oldq_pkg::ST_EMPTY;
        end else if (any_hit) begin
          hit_nxt = 1'b1;
          for (int i = 0; i < oldq_pkg::DEPTH - 1; i++) begin
            if (shift_mask[i]) begin
              entries_nxt[i] = entries_r[i+1];
            end
          end
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = oldq_pkg::ST_NOTFOUND;
        end
      end
      oldq_pkg::OP_SEARCH: begin
        if (any_hit) begin
          hit_nxt = 1'b1;
        end else begin
          status_nxt = oldq_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
    end
    if (cmd.compare) begin
      match_r <= match_nxt;
    end
    if (cmd.apply) begin
      for (int i = 0; i < oldq_pkg::DEPTH; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
      status_r    <= status_nxt;
      hit_r       <= hit_nxt;
      out_count_r <= oldq_pkg::count_t'(count_nxt);
    end
  end

  assign out_status = status_r;
  assign out_hit    = hit_r;
  assign out_count  = out_count_r;

endmodule

/* rtl/oldq_ctrl.sv */
// Controller of the ordered list deque engine: sequences accept, compare and
// update for each item and owns the input and result handshakes.
// Depends on oldq_pkg; drives oldq_dp through the command struct.
module oldq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output oldq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   apply;

  assign accept = in_valid && in_ready_r;
  assign apply  = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready_nxt = !accept;
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply) begin
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.load    = accept;
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.apply   = apply;
  assign in_ready    = in_ready_r;
  assign out_valid   = out_valid_r;

endmodule

/* rtl/ordered_list_deque_engine.sv */
// Top level of the ordered list deque engine: an ordered list of up to
// sixteen signed 32-bit values, front at position zero, held in a row of
// cells. Each item is one request (push front or back, pop front or back,
// remove the first equal value, or search) and yields exactly one result with
// a status, a hit flag and the new count. An item passes three steps from
// acceptance to the next ready: it is captured, then every cell compares
// against the value in parallel, then the cells shift and the result register
// loads. The result then waits in its register while the next item is taken;
// the update of the following item stalls only while an untaken result still
// holds that register. Depends on oldq_pkg, oldq_ctrl and oldq_dp.
module ordered_list_deque_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [oldq_pkg::OP_W-1:0]           in_op,
  input  logic signed [oldq_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oldq_pkg::STAT_W-1:0]         out_status,
  output logic                                out_hit,
  output logic [oldq_pkg::COUNT_W-1:0]        out_count
);

  oldq_pkg::cmd_t cmd;

  oldq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  oldq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_status (out_status),
    .out_hit    (out_hit),
    .out_count  (out_count)
  );

endmodule

/* test/tb_ordered_list_deque_engine.sv */
// Testbench for ordered_list_deque_engine: drives list requests through the
// valid/ready input channel and checks every result against its own list model.
// Depends on oldq_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_ordered_list_deque_engine;
  import oldq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam int MODE_FILL     = 0;
  localparam int MODE_DRAIN    = 1;
  localparam int MODE_MIXED    = 2;
  localparam int RANDOM_ITEMS  = 650;
  localparam int BLOCK_ITEMS   = 40;
  localparam int TAIL_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 500;

  typedef struct {
    logic [OP_W-1:0] op;
    data_t           value;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               hit;
    logic [COUNT_W-1:0] count;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = '0;
  data_t               in_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic                out_hit;
  logic [COUNT_W-1:0]  out_count;

  request_t request_q[$];
  reply_t   reply_q[$];
  data_t    list_mem [DEPTH];
  int       list_len = 0;

  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_hits = 0;
  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int cycle_no = 0;
  int stall_cycles = 0;

  ordered_list_deque_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_hit    (out_hit),
    .out_count  (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic reply_t apply_request(logic [OP_W-1:0] op, data_t value);
    reply_t r;
    int     match;
    int     gap;
    int     idx;
    r.status = ST_DONE;
    r.hit    = 1'b0;
    match    = -1;
    gap      = -1;
    for (idx = 0; idx < list_len; idx++) begin
      if (match < 0 && list_mem[idx] == value) match = idx;
    end
    case (op)
      OP_PUSH_FRONT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (idx = list_len; idx > 0; idx--) list_mem[idx] = list_mem[idx-1];
          list_mem[0] = value;
          list_len++;
        end
      end
      OP_PUSH_BACK: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      OP_POP_FRONT: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else gap = 0;
      end
      OP_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      OP_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (match >= 0) begin
          r.hit = 1'b1;
          gap   = match;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_SEARCH: begin
        if (match >= 0) r.hit = 1'b1;
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    if (gap >= 0) begin
      for (idx = gap; idx < list_len - 1; idx++) list_mem[idx] = list_mem[idx+1];
      list_len--;
    end
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, data_t value);
    request_t req;
    req.op    = op;
    req.value = value;
    request_q.push_back(req);
  endtask

  always @(posedge clk) begin : drive
    request_t req;
    logic     held;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
      in_gap    <= 0;
      out_gap   <= 0;
    end else begin
      cycle_no = cycle_no + 1;
      if (cycle_no % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
      end
      held = in_valid && !in_ready;
      if (!held) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct) begin
          in_gap   <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else begin
          req = request_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= req.op;
          in_value <= req.value;
        end
      end
      if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct) begin
        out_gap   <= $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    reply_t want;
    logic   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        want = apply_request(in_op, in_value);
        reply_q.push_back(want);
        n_sent++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (want.hit) n_hits++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        n_checked++;
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected item, status %0d hit %0d count %0d", $time,
                   out_status, out_hit, out_count);
          n_errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_status);
            n_errors++;
          end
          if (out_hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0d, actual %0d", $time,
                     want.hit, out_hit);
            n_errors++;
          end
          if (out_count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d", $time,
                     want.count, out_count);
            n_errors++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, reply_q.size());
        $display("tb_ordered_list_deque_engine: errors");
        $finish;
      end
    end
  end

  initial begin
    int    cut [3][6];
    data_t pool [8];
    int    mode;
    int    k;
    int    j;
    int    r;
    int    sel;
    logic [OP_W-1:0] op;
    data_t value;

    cut  = '{'{35, 70, 77, 84, 91, 98}, '{10, 20, 45, 70, 85, 98},
             '{20, 40, 52, 64, 80, 96}};
    pool = '{32'sh0000_0000, 32'sh0000_0001, -32'sd1, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh0000_0005, 32'sh8000_0005, 32'sh0001_0005};

    // Directed opening: empty-list corner cases, unused codes, extremes,
    // duplicates, and removal of the first match only.
    add_request(OP_SEARCH, 32'sh0);
    add_request(OP_POP_FRONT, 32'sh0);
    add_request(OP_POP_BACK, -32'sd1);
    add_request(OP_REMOVE, 32'sh0);
    add_request(OP_UNUSED_6, 32'sh1234_5678);
    add_request(OP_UNUSED_7, -32'sd1);
    add_request(OP_PUSH_FRONT, 32'sh8000_0000);
    add_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    add_request(OP_PUSH_FRONT, -32'sd1);
    add_request(OP_PUSH_BACK, 32'sh0);
    add_request(OP_PUSH_BACK, -32'sd1);
    add_request(OP_SEARCH, -32'sd1);
    add_request(OP_SEARCH, 32'sh8000_0005);
    add_request(OP_REMOVE, -32'sd1);
    add_request(OP_SEARCH, -32'sd1);
    add_request(OP_REMOVE, 32'sd12345);
    add_request(OP_UNUSED_6, 32'sh0);
    add_request(OP_POP_BACK, 32'sh0);
    add_request(OP_POP_FRONT, 32'sh0);
    add_request(OP_REMOVE, 32'sh7FFF_FFFF);
    add_request(OP_REMOVE, 32'sh0);
    add_request(OP_SEARCH, 32'sh0);
    add_request(OP_UNUSED_7, 32'sh0);

    mode = MODE_FILL;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % BLOCK_ITEMS == 0 && k != 0) mode = $urandom_range(MODE_FILL, MODE_MIXED);
      r   = $urandom_range(0, 99);
      sel = 6;
      for (j = 5; j >= 0; j--) begin
        if (r < cut[mode][j]) sel = j;
      end
      if (sel == 6) op = r[0] ? OP_UNUSED_7 : OP_UNUSED_6;
      else op = op_t'(sel);
      if ($urandom_range(0, 99) < 55) value = pool[$urandom_range(0, 7)];
      else value = $urandom();
      add_request(op, value);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(negedge clk);
    while (reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d requests and checked %0d results, with random stalls on both sides.",
             n_sent, n_checked);
    $display("Seen: %0d inserts dropped on a full list, %0d requests on an empty list, %0d hits.",
             n_full, n_empty, n_hits);
    if (n_errors == 0) begin
      $display("tb_ordered_list_deque_engine: clean");
    end else begin
      $display("tb_ordered_list_deque_engine: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/oldq_pkg.sv
rtl/oldq_dp.sv
rtl/oldq_ctrl.sv
rtl/ordered_list_deque_engine.sv
test/tb_ordered_list_deque_engine.sv
